// ===== hw/rtl/epst_pkg.sv =====
// Shared constants and types for the Euclidean spanning tree block.
package epst_pkg;
  localparam int MAX_POINTS = 64;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;
  localparam int COORD_W = 16;
  localparam int SQ_W = 33;
  localparam int LEN_W = 25;

  typedef struct packed {
    logic load;
    logic [IDX_W-1:0] load_addr;
    logic init;
    logic [IDX_W-1:0] rd_addr;
    logic scan_first;
    logic scan_acc;
    logic take;
    logic upd_acc;
    logic sqrt_start;
    logic [IDX_W-1:0] out_addr;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic sqrt_done;
  } stat_t;
endpackage

// ===== hw/rtl/epst_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module epst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/epst_datapath.sv =====
// Datapath: point memories, keys, distance, selection and square root.
module epst_datapath (
  input  logic clk,
  input  logic rst,
  input  epst_pkg::cmd_t cmd,
  input  logic signed [epst_pkg::COORD_W-1:0] in_x,
  input  logic signed [epst_pkg::COORD_W-1:0] in_y,
  output epst_pkg::stat_t stat,
  output logic [epst_pkg::IDX_W-1:0] parent_out,
  output logic reached_out,
  output logic [epst_pkg::SQ_W-1:0] sq_out,
  output logic [epst_pkg::LEN_W-1:0] len_out
);
  import epst_pkg::*;

  logic [2*COORD_W-1:0] xy_rd;
  logic [2*COORD_W-1:0] xy_u;
  logic [IDX_W-1:0] xy_raddr;
  logic [SQ_W+IDX_W-1:0] kp_rd;
  logic [SQ_W+IDX_W-1:0] kp_wdata;
  logic [IDX_W-1:0] kp_waddr;
  logic kp_we;
  logic [SQ_W-1:0] key_rd;
  logic [IDX_W-1:0] par_rd;
  logic [SQ_W-1:0] key_d2;
  logic [SQ_W-1:0] key_d3;
  logic [MAX_POINTS-1:0] kvalid;
  logic [MAX_POINTS-1:0] intree;
  logic [IDX_W-1:0] rd_d1;
  logic [IDX_W-1:0] rd_d2;
  logic [IDX_W-1:0] rd_d3;
  logic [IDX_W-1:0] best_idx;
  logic [SQ_W-1:0] best_val;
  logic found;
  logic [IDX_W-1:0] u_idx;
  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] dy;
  logic [COORD_W:0] ax;
  logic [COORD_W:0] ay;
  logic [2*COORD_W+1:0] px;
  logic [2*COORD_W+1:0] py;
  logic [SQ_W-1:0] dsq;
  logic upd_hit;
  logic scan_d1;
  logic take_d1;
  logic start_d1;
  logic acc_d1;
  logic acc_d2;
  logic acc_d3;
  logic [49:0] rem;
  logic [49:0] cand;
  logic [49:0] trial;
  logic [LEN_W-1:0] root;
  logic [4:0] sqrt_cnt;
  logic sqrt_busy;

  function automatic logic [1:0] sq_pair(input logic [SQ_W-1:0] s, input logic [4:0] k);
    logic [49:0] v;
    v = {1'b0, s, 16'd0};
    return v[2*k +: 2];
  endfunction

  assign xy_raddr = cmd.take ? best_idx : cmd.rd_addr;

  epst_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_POINTS)) u_xy (
    .clk(clk), .we(cmd.load), .waddr(cmd.load_addr), .wdata({in_y, in_x}),
    .raddr(xy_raddr), .rdata(xy_rd)
  );

  assign key_rd = kp_rd[SQ_W-1:0];
  assign par_rd = kp_rd[SQ_W+IDX_W-1:SQ_W];
  assign upd_hit = acc_d3 && !intree[rd_d3] && dsq != '0
                   && (!kvalid[rd_d3] || dsq < key_d3);
  assign kp_we = cmd.init || upd_hit;
  assign kp_waddr = cmd.init ? '0 : rd_d3;
  assign kp_wdata = cmd.init ? '0 : {u_idx, dsq};

  epst_ram #(.WIDTH(SQ_W+IDX_W), .DEPTH(MAX_POINTS)) u_kp (
    .clk(clk), .we(kp_we), .waddr(kp_waddr), .wdata(kp_wdata),
    .raddr(cmd.rd_addr), .rdata(kp_rd)
  );

  assign stat.found = found;
  assign stat.sqrt_done = !sqrt_busy && !start_d1;

  always_comb begin
    ax = dx[COORD_W] ? -dx : dx;
    ay = dy[COORD_W] ? -dy : dy;
    dsq = SQ_W'(px + py);
    cand = {rem[47:0], sq_pair(sq_out, sqrt_cnt)};
    trial = {23'd0, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    rd_d1 <= cmd.rd_addr;
    rd_d2 <= rd_d1;
    rd_d3 <= rd_d2;
    key_d2 <= key_rd;
    key_d3 <= key_d2;
    if (take_d1) begin
      xy_u <= xy_rd;
    end
    dx <= $signed({xy_rd[COORD_W-1], xy_rd[COORD_W-1:0]})
        - $signed({xy_u[COORD_W-1], xy_u[COORD_W-1:0]});
    dy <= $signed({xy_rd[2*COORD_W-1], xy_rd[2*COORD_W-1:COORD_W]})
        - $signed({xy_u[2*COORD_W-1], xy_u[2*COORD_W-1:COORD_W]});
    px <= ax * ax;
    py <= ay * ay;
    if (rst) begin
      kvalid <= '0;
      intree <= '0;
      found <= 1'b0;
      sqrt_busy <= 1'b0;
      scan_d1 <= 1'b0;
      take_d1 <= 1'b0;
      start_d1 <= 1'b0;
      acc_d1 <= 1'b0;
      acc_d2 <= 1'b0;
      acc_d3 <= 1'b0;
    end else begin
      scan_d1 <= cmd.scan_acc;
      take_d1 <= cmd.take;
      start_d1 <= cmd.sqrt_start;
      acc_d1 <= cmd.upd_acc;
      acc_d2 <= acc_d1;
      acc_d3 <= acc_d2;
      if (cmd.init) begin
        kvalid <= MAX_POINTS'(1);
        intree <= '0;
      end
      if (cmd.scan_first) begin
        found <= 1'b0;
      end
      if (scan_d1 && !intree[rd_d1] && kvalid[rd_d1]
          && (!found || key_rd < best_val)) begin
        found <= 1'b1;
        best_val <= key_rd;
        best_idx <= rd_d1;
      end
      if (cmd.take) begin
        intree[best_idx] <= 1'b1;
        u_idx <= best_idx;
      end
      if (upd_hit) begin
        kvalid[rd_d3] <= 1'b1;
      end
      if (start_d1) begin
        sqrt_busy <= 1'b1;
        sqrt_cnt <= 5'd24;
        rem <= '0;
        root <= '0;
        sq_out <= (kvalid[cmd.out_addr] && cmd.out_addr != '0) ? key_rd : '0;
        parent_out <= (kvalid[cmd.out_addr] && cmd.out_addr != '0) ? par_rd : '0;
        reached_out <= kvalid[cmd.out_addr];
      end else if (sqrt_busy) begin
        // one root bit per cycle over the 49-bit radicand sq<<16
        if (cand >= trial) begin
          rem <= cand - trial;
          root <= {root[LEN_W-2:0], 1'b1};
        end else begin
          rem <= cand;
          root <= {root[LEN_W-2:0], 1'b0};
        end
        if (sqrt_cnt == 5'd0) begin
          sqrt_busy <= 1'b0;
        end else begin
          sqrt_cnt <= sqrt_cnt - 5'd1;
        end
      end
    end
  end

  assign len_out = root;
endmodule

// ===== hw/rtl/epst_ctrl.sv =====
// Controller: load, Prim steps, result streaming.
module epst_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_last,
  output logic out_valid,
  input  logic out_ready,
  output logic [epst_pkg::IDX_W-1:0] out_index,
  output logic out_last,
  output epst_pkg::cmd_t cmd,
  input  epst_pkg::stat_t stat
);
  import epst_pkg::*;

  typedef enum logic [2:0] {LOAD, SCAN, TAKE, UPD, EMIT, SQRT, HOLD} state_t;
  state_t state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] step;
  logic [CNT_W-1:0] pos;
  logic [IDX_W-1:0] vtx;

  assign in_ready = (state == LOAD);

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready && count < CNT_W'(MAX_POINTS);
    cmd.load_addr = count[IDX_W-1:0];
    cmd.init = in_valid && in_ready && in_last;
    cmd.rd_addr = pos[IDX_W-1:0];
    cmd.scan_first = (state == SCAN) && pos == '0;
    cmd.scan_acc = (state == SCAN) && pos < count;
    cmd.take = (state == TAKE);
    cmd.upd_acc = (state == UPD) && pos < count;
    cmd.sqrt_start = (state == EMIT);
    cmd.out_addr = vtx;
    if (state == EMIT) begin
      cmd.rd_addr = vtx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        LOAD: begin
          if (in_valid) begin
            if (count < CNT_W'(MAX_POINTS)) count <= count + 1'b1;
            if (in_last) begin
              step <= CNT_W'(1);
              pos <= '0;
              if (count == '0 || (count == CNT_W'(1) && !(count < CNT_W'(MAX_POINTS))))
                state <= EMIT;
              else if (count + 1'b1 <= CNT_W'(1) && count < CNT_W'(MAX_POINTS))
                state <= EMIT;
              else
                state <= SCAN;
              if (count < CNT_W'(MAX_POINTS)) count <= count + 1'b1;
              vtx <= '0;
            end
          end
        end
        SCAN: begin
          if (pos == count + CNT_W'(1)) begin
            pos <= '0;
            state <= stat.found ? TAKE : EMIT;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        TAKE: state <= HOLD;
        HOLD: begin
          pos <= '0;
          state <= UPD;
        end
        UPD: begin
          if (pos == count + CNT_W'(2)) begin
            pos <= '0;
            step <= step + 1'b1;
            state <= (step + 1'b1 == count) ? EMIT : SCAN;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        EMIT: state <= SQRT;
        SQRT: begin
          if (stat.sqrt_done && !out_valid) begin
            out_valid <= 1'b1;
            out_index <= vtx;
            out_last <= (CNT_W'(vtx) + 1'b1 == count);
          end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              count <= '0;
              state <= LOAD;
            end else begin
              vtx <= vtx + 1'b1;
              state <= EMIT;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end
endmodule

// ===== hw/rtl/euclidean_prim_spanning_tree.sv =====
// Top level: Euclidean minimum spanning tree by Prim's method.
// Points load one word per cycle; the word with tlast starts the tree. Each of
// the N-1 Prim steps is one key scan and one distance sweep over the point
// memory; then each result waits for the bit-serial square root.
module euclidean_prim_spanning_tree (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [31:0] s_tdata,   // point_x, point_y
  input  logic s_tlast,          // last_point
  output logic m_tvalid,
  input  logic m_tready,
  output logic [71:0] m_tdata,   // vertex_index, parent_index, is_root, reached,
                                 // squared_length, edge_length
  output logic m_tlast           // last_result
);
  import epst_pkg::*;

  cmd_t cmd;
  stat_t stat;
  logic [IDX_W-1:0] vidx;
  logic [IDX_W-1:0] par;
  logic reach;
  logic [SQ_W-1:0] sq;
  logic [LEN_W-1:0] len;

  epst_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready), .in_last(s_tlast),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_index(vidx), .out_last(m_tlast),
    .cmd(cmd), .stat(stat)
  );

  epst_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_x(s_tdata[15:0]), .in_y(s_tdata[31:16]),
    .stat(stat), .parent_out(par), .reached_out(reach), .sq_out(sq), .len_out(len)
  );

  assign m_tdata = {len, sq, reach, (vidx == '0), par, vidx};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast));
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid));
  a_root: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && vidx == '0 |-> reach);
  a_unreached: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !reach |-> sq == '0 && par == '0);
endmodule
